// ===== hw/rtl/pclg_pkg.sv =====
`timescale 1ns / 1ps

package pclg_pkg;

    localparam int MAX_LOOP_SLOTS = 8;
    localparam int PITCH_BITS     = 16;
    localparam int LOOP_IDX_W     = $clog2(MAX_LOOP_SLOTS);
    localparam int NUM_W          = 32;   // widest dividend: 32768 * (2 * pitch)
    localparam int DEN_W          = PITCH_BITS + 1;
    localparam int CNT_W          = $clog2(NUM_W + 1);

    localparam logic [15:0] UNITY      = 16'h8000;
    localparam logic [15:0] RATIO_MAX  = 16'hFFFF;
    localparam logic [3:0]  SLOT_START = 4'd0;
    localparam logic [3:0]  SLOT_STOP  = 4'(MAX_LOOP_SLOTS + 1);

    // register indexes of the config channel
    localparam logic [2:0] CFG_LOOP_COUNT  = 3'd0;
    localparam logic [2:0] CFG_PITCH_LOW   = 3'd1;
    localparam logic [2:0] CFG_PITCH_HIGH  = 3'd2;
    localparam logic [2:0] CFG_START_PITCH = 3'd3;
    localparam logic [2:0] CFG_STOP_PITCH  = 3'd4;
    localparam logic [2:0] CFG_PRESENCE    = 3'd5;

    localparam logic FUNC_PITCH = 1'b0;
    localparam logic FUNC_GAIN  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PLAN,
        ST_FWAIT,
        ST_CHK,
        ST_RWAIT,
        ST_STORE,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic search;
        logic fade_const;
        logic fade_start;
        logic fade_take;
        logic ratio_start;
        logic ratio_take;
        logic store;
        logic mul;
        logic next;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic any;
        logic more;
        logic fade_div;
        logic want_ratio;
        logic div_done;
        logic out_taken;
    } t_sts;

    // sample pitch of loop slot idx; slots past the table read zero
    function automatic logic [PITCH_BITS-1:0] pitch_of(input logic [63:0] lo_word,
                                                      input logic [63:0] hi_word,
                                                      input logic [3:0]  idx);
        logic [63:0] w;
        logic [PITCH_BITS-1:0] p;
        w = idx[2] ? hi_word : lo_word;
        case (idx[1:0])
            2'd0:    p = w[15:0];
            2'd1:    p = w[31:16];
            2'd2:    p = w[47:32];
            default: p = w[63:48];
        endcase
        return idx[3] ? '0 : p;
    endfunction

endpackage

// ===== hw/rtl/pclg_div.sv =====
`timescale 1ns / 1ps

module pclg_div import pclg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_n;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        rem_n  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= rem_n;
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/pclg_dp.sv =====
`timescale 1ns / 1ps

module pclg_dp import pclg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_func,
    input  logic [15:0] i_value,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [3:0]  o_slot,
    output logic [15:0] o_gain,
    output logic [15:0] o_ratio,
    output logic        o_retune,
    output logic        o_last
);

    typedef struct packed {
        logic                  fdiv;
        logic [15:0]           fconst;
        logic [NUM_W-1:0]      num;
        logic [DEN_W-1:0]      den;
        logic                  rt_cand;
        logic                  rt_nz;
        logic [PITCH_BITS-1:0] rden;
    } t_plan;

    // fade below a sample pitch
    function automatic t_plan low_plan(input logic [15:0] s, input logic [15:0] v);
        t_plan       p;
        logic [19:0] v3, v5, v15, s3, x;
        v3  = 20'(v) * 20'd3;
        v5  = 20'(v) * 20'd5;
        v15 = 20'(v) * 20'd15;
        s3  = 20'(s) * 20'd3;
        x   = v15 - s3;
        p = '0;
        p.rden = s;
        if (s == '0) begin
            p.fconst = UNITY;
        end else if (v3 > 20'(s)) begin
            p.fconst  = UNITY;
            p.rt_cand = 1'b1;
        end else if (v5 < 20'(s)) begin
            p.fconst = '0;
        end else begin
            p.fdiv    = 1'b1;
            p.num     = {x[16:0], 15'd0};
            p.den     = {s, 1'b0};
            p.rt_cand = 1'b1;
            p.rt_nz   = 1'b1;
        end
        return p;
    endfunction

    // config registers
    logic [3:0]  r_loop_count;
    logic [63:0] r_pw_low, r_pw_high;
    logic [15:0] r_start_pitch, r_stop_pitch;
    logic [1:0]  r_presence;

    // item and per-slot state
    logic        r_func;
    logic [15:0] r_v;
    logic [3:0]  r_up;
    logic [3:0]  r_slot;
    logic [15:0] r_fade;
    logic [15:0] r_ratio;
    logic        r_rt;
    logic [15:0] r_master;
    logic [15:0] r_loop_fade [MAX_LOOP_SLOTS];
    logic [15:0] r_start_fade, r_stop_fade;

    logic        r_valid;
    logic [3:0]  r_o_slot;
    logic [15:0] r_o_gain, r_o_ratio;
    logic        r_o_rt, r_o_last;

    logic [3:0]  cnt;
    logic        has_start, has_stop;
    logic [3:0]  first_slot, next_slot;
    logic        any, more;
    logic [3:0]  up_c;
    logic [3:0]  li, lo;
    logic [15:0] pi, pl, pu, pt, span;
    t_plan       plan;
    logic        want_ratio;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] quo;
    logic        div_done;
    logic [15:0] fade_sel;
    logic [31:0] prod;

    assign cnt       = (r_loop_count > 4'(MAX_LOOP_SLOTS)) ? 4'(MAX_LOOP_SLOTS) : r_loop_count;
    assign has_start = r_presence[0];
    assign has_stop  = r_presence[1];

    // slot order: start, loops, stop
    always_comb begin
        any        = has_start || (cnt != '0) || has_stop;
        first_slot = has_start ? SLOT_START : ((cnt != '0) ? 4'd1 : SLOT_STOP);
        more       = 1'b0;
        next_slot  = SLOT_STOP;
        if (r_slot == SLOT_START) begin
            more      = (cnt != '0) || has_stop;
            next_slot = (cnt != '0) ? 4'd1 : SLOT_STOP;
        end else if (r_slot != SLOT_STOP) begin
            more      = (r_slot < cnt) || has_stop;
            next_slot = (r_slot < cnt) ? r_slot + 4'd1 : SLOT_STOP;
        end
    end

    // first slot pitched above the target
    always_comb begin
        up_c = cnt;
        for (int j = MAX_LOOP_SLOTS - 1; j >= 0; j--) begin
            if ((4'(j) < cnt) && (pitch_of(r_pw_low, r_pw_high, 4'(j)) > r_v)) begin
                up_c = 4'(j);
            end
        end
    end

    always_comb begin
        li   = r_slot - 4'd1;
        lo   = r_up - 4'd1;
        pi   = pitch_of(r_pw_low, r_pw_high, li);
        pl   = pitch_of(r_pw_low, r_pw_high, lo);
        pu   = pitch_of(r_pw_low, r_pw_high, r_up);
        pt   = pitch_of(r_pw_low, r_pw_high, cnt - 4'd1);
        span = pu - pl;
        plan = '0;
        plan.fconst = (pi != '0) ? 16'd0 : UNITY;
        plan.rden   = pi;
        if (r_slot == SLOT_START) begin
            plan = low_plan(r_start_pitch, r_v);
        end else if (r_slot == SLOT_STOP) begin
            plan = low_plan(r_stop_pitch, r_v);
        end else if (r_up == '0) begin
            if (li == '0) plan = low_plan(pi, r_v);
        end else if (r_up == cnt) begin
            if (li == cnt - 4'd1) begin
                plan.fconst  = UNITY;
                plan.rt_cand = (pt != '0);
            end
        end else if (li == lo) begin
            plan.fconst = UNITY;
            if (pl != '0) begin
                plan.fdiv    = 1'b1;
                plan.num     = NUM_W'({pu - r_v, 15'd0});
                plan.den     = {1'b0, span};
                plan.rt_cand = 1'b1;
            end
        end else if (li == r_up) begin
            plan.fconst = UNITY;
            if (pu != '0) begin
                plan.fdiv    = 1'b1;
                plan.num     = NUM_W'({r_v - pl, 15'd0});
                plan.den     = {1'b0, span};
                plan.rt_cand = 1'b1;
            end
        end
        want_ratio = plan.rt_cand && (!plan.rt_nz || (r_fade != '0));
    end

    assign div_num = i_cmd.ratio_start ? NUM_W'({r_v, 12'd0}) : plan.num;
    assign div_den = i_cmd.ratio_start ? {1'b0, plan.rden} : plan.den;

    pclg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.fade_start || i_cmd.ratio_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    always_comb begin
        if (r_slot == SLOT_START)     fade_sel = r_start_fade;
        else if (r_slot == SLOT_STOP) fade_sel = r_stop_fade;
        else                          fade_sel = r_loop_fade[li[LOOP_IDX_W-1:0]];
        prod = 32'(r_master) * 32'(fade_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_count  <= '0;
            r_pw_low      <= '0;
            r_pw_high     <= '0;
            r_start_pitch <= '0;
            r_stop_pitch  <= '0;
            r_presence    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOOP_COUNT:  r_loop_count  <= i_cfg_data[3:0];
                CFG_PITCH_LOW:   r_pw_low      <= i_cfg_data;
                CFG_PITCH_HIGH:  r_pw_high     <= i_cfg_data;
                CFG_START_PITCH: r_start_pitch <= i_cfg_data[15:0];
                CFG_STOP_PITCH:  r_stop_pitch  <= i_cfg_data[15:0];
                CFG_PRESENCE:    r_presence    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master     <= UNITY;
            r_start_fade <= '0;
            r_stop_fade  <= '0;
            for (int k = 0; k < MAX_LOOP_SLOTS; k++) r_loop_fade[k] <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cmd.search && (r_func == FUNC_GAIN)) begin
                r_master <= (r_v > UNITY) ? UNITY : r_v;
            end
            if (i_cmd.store) begin
                if (r_slot == SLOT_START)     r_start_fade <= r_fade;
                else if (r_slot == SLOT_STOP) r_stop_fade  <= r_fade;
                else                          r_loop_fade[li[LOOP_IDX_W-1:0]] <= r_fade;
            end
            if (i_cmd.mul)               r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_v     <= i_value;
            r_rt    <= 1'b0;
            r_ratio <= '0;
        end
        if (i_cmd.search) begin
            r_up   <= up_c;
            r_slot <= first_slot;
        end
        if (i_cmd.next) r_slot <= next_slot;
        if (i_cmd.fade_const || i_cmd.fade_take) begin
            r_fade  <= i_cmd.fade_take ? quo[15:0] : plan.fconst;
            r_rt    <= 1'b0;
            r_ratio <= '0;
        end
        if (i_cmd.ratio_take) begin
            r_rt    <= 1'b1;
            r_ratio <= (quo > NUM_W'(RATIO_MAX)) ? RATIO_MAX : quo[15:0];
        end
        if (i_cmd.mul) begin
            r_o_slot  <= r_slot;
            r_o_gain  <= prod[30:15];
            r_o_ratio <= r_ratio;
            r_o_rt    <= r_rt;
            r_o_last  <= !more;
        end
    end

    always_comb begin
        o_sts.func       = r_func;
        o_sts.any        = any;
        o_sts.more       = more;
        o_sts.fade_div   = plan.fdiv;
        o_sts.want_ratio = want_ratio;
        o_sts.div_done   = div_done;
        o_sts.out_taken  = r_valid && i_ready;
    end

    assign o_valid  = r_valid;
    assign o_slot   = r_o_slot;
    assign o_gain   = r_o_gain;
    assign o_ratio  = r_o_ratio;
    assign o_retune = r_o_rt;
    assign o_last   = r_o_last;

endmodule

// ===== hw/rtl/pclg_ctrl.sv =====
`timescale 1ns / 1ps

module pclg_ctrl import pclg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (!i_sts.any)                 n_state = ST_IDLE;
                else if (i_sts.func == FUNC_GAIN) n_state = ST_MUL;
                else                            n_state = ST_PLAN;
            end
            ST_PLAN:   n_state = i_sts.fade_div ? ST_FWAIT : ST_CHK;
            ST_FWAIT:  if (i_sts.div_done) n_state = ST_CHK;
            ST_CHK:    n_state = i_sts.want_ratio ? ST_RWAIT : ST_STORE;
            ST_RWAIT:  if (i_sts.div_done) n_state = ST_STORE;
            ST_STORE:  n_state = ST_MUL;
            ST_MUL:    n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_taken) begin
                    if (!i_sts.more)                  n_state = ST_IDLE;
                    else if (i_sts.func == FUNC_GAIN) n_state = ST_MUL;
                    else                              n_state = ST_PLAN;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SEARCH: o_cmd.search = 1'b1;
            ST_PLAN: begin
                o_cmd.fade_start = i_sts.fade_div;
                o_cmd.fade_const = !i_sts.fade_div;
            end
            ST_FWAIT:  o_cmd.fade_take = i_sts.div_done;
            ST_CHK:    o_cmd.ratio_start = i_sts.want_ratio;
            ST_RWAIT:  o_cmd.ratio_take = i_sts.div_done;
            ST_STORE:  o_cmd.store = 1'b1;
            ST_MUL:    o_cmd.mul = 1'b1;
            ST_OUT:    o_cmd.next = i_sts.out_taken && i_sts.more;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/pitch_layer_crossfade_gains.sv =====
`timescale 1ns / 1ps
// set-gain items run a search, then a multiply and an output per present slot; set-pitch
//   items add per slot a plan, optional fade division, ratio check, optional ratio division,
//   store, multiply and output; one item at a time, and the single shared bit-serial
//   divider (32 quotient bits, one per cycle) serves both the fade and the ratio division
// reset: synchronous active low; config clears to zero, fades to zero, master gain to unity

module pitch_layer_crossfade_gains import pclg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value
    input  logic        s_tuser,   // [0] func
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] slot, [19:4] slot_gain, [35:20] pitch_ratio, pad
    output logic        m_tuser,   // [0] retune
    output logic        m_tlast,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    t_cmd        cmd;
    t_sts        sts;
    logic [3:0]  slot;
    logic [15:0] gain;
    logic [15:0] ratio;

    // config writes are always taken; the sender must write them only while idle, the block itself does not enforce it
    assign cfg_ready = 1'b1;

    // sequencer: search, per-slot fade and ratio, output transfer
    pclg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // registers, table search, shared divider and gain multiplier
    pclg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (s_tuser),
        .i_value     (s_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_ready     (m_tready),
        .o_valid     (m_tvalid),
        .o_slot      (slot),
        .o_gain      (gain),
        .o_ratio     (ratio),
        .o_retune    (m_tuser),
        .o_last      (m_tlast)
    );

    // pack result fields, low field first
    assign m_tdata = {4'd0, ratio, gain, slot};

`ifndef ASSERT_OFF
    // no new item is taken while a result is still pending
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");

    // slot codes stay within start, loops and stop
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[3:0] <= SLOT_STOP)) else $error("slot out of range");

    // gain never exceeds unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[19:4] <= UNITY)) else $error("gain above unity");

    // ratio is zero unless the slot is retuned
    a_ratio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[35:20] == 16'd0))
        else $error("ratio without retune");
`endif

endmodule

// ===== verif/pitch_layer_crossfade_gains_tb.sv =====
`timescale 1ns / 1ps

module pitch_layer_crossfade_gains_tb;
    import pclg_pkg::*;

    // bench limits
    localparam int STALL_LIMIT = 20000;   // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 800;    // idle margin once all results are in

    // one predicted result item
    typedef struct {
        logic [3:0]  slot;
        logic [15:0] slot_gain;
        logic [15:0] pitch_ratio;
        logic        retune;
        logic        last;
    } t_slot_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    pitch_layer_crossfade_gains u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the registers and the gain state
    logic [3:0]  loop_count_q;
    logic [63:0] pitch_low_q;
    logic [63:0] pitch_high_q;
    logic [15:0] start_pitch_q;
    logic [15:0] stop_pitch_q;
    logic [1:0]  presence_q;
    logic [15:0] loop_fade_q [MAX_LOOP_SLOTS];
    logic [15:0] start_fade_q;
    logic [15:0] stop_fade_q;
    logic [15:0] master_gain_q;

    t_slot_result pending_results[$];
    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  retuned_seen = 0;
    int  idle_cycles = 0;
    bit  sink_stall_on = 1'b1;

    function automatic logic [63:0] loop_pitch(int idx);
        logic [63:0] w;
        if (idx >= 8) return 64'd0;
        w = (idx < 4) ? pitch_low_q : pitch_high_q;
        return (w >> ((idx % 4) * 16)) & 64'hFFFF;
    endfunction

    // fade below a sample pitch: silent under s/5, unity above s/3
    function automatic logic [15:0] below_fade(logic [63:0] s, logic [63:0] v);
        if (s == 0) return UNITY;
        if (3 * v > s) return UNITY;
        if (5 * v < s) return 16'd0;
        return 16'((64'd32768 * (15 * v - 3 * s)) / (2 * s));
    endfunction

    function automatic logic [15:0] pitch_quotient(logic [63:0] v, logic [63:0] s);
        logic [63:0] q;
        if (s == 0) return 16'd0;
        q = (v << 12) / s;
        return (q > 64'hFFFF) ? RATIO_MAX : q[15:0];
    endfunction

    function automatic logic [15:0] idle_gain(logic [63:0] s);
        return (s != 0) ? 16'd0 : UNITY;
    endfunction

    function automatic t_slot_result make_result(logic [3:0] slot, logic [15:0] fade,
                                                 logic [15:0] ratio, logic rt);
        t_slot_result r;
        logic [31:0] prod;
        prod = 32'(master_gain_q) * 32'(fade);
        r.slot = slot;
        r.slot_gain = prod[30:15];
        r.pitch_ratio = rt ? ratio : 16'd0;
        r.retune = rt;
        r.last = 1'b0;
        return r;
    endfunction

    // update the gain state for one item and queue what it emits
    task automatic predict_gains(logic func, logic [15:0] value);
        logic [63:0] v;
        int          cnt;
        int          up;
        int          lo;
        logic [63:0] pl;
        logic [63:0] pu;
        logic [15:0] ratio [MAX_LOOP_SLOTS];
        logic        rt [MAX_LOOP_SLOTS];
        logic [15:0] start_ratio;
        logic [15:0] stop_ratio;
        logic        start_rt;
        logic        stop_rt;
        t_slot_result batch[$];
        v = 64'(value);
        cnt = (loop_count_q > MAX_LOOP_SLOTS) ? MAX_LOOP_SLOTS : loop_count_q;
        start_ratio = 0; stop_ratio = 0; start_rt = 0; stop_rt = 0;
        for (int i = 0; i < MAX_LOOP_SLOTS; i++) begin
            ratio[i] = 0;
            rt[i] = 0;
        end
        if (func == FUNC_GAIN) begin
            master_gain_q = (value > UNITY) ? UNITY : value;
        end else begin
            if (presence_q[0]) begin
                start_fade_q = below_fade(start_pitch_q, v);
                if (start_fade_q != 0 && start_pitch_q != 0) begin
                    start_ratio = pitch_quotient(v, start_pitch_q);
                    start_rt = 1;
                end
            end
            if (cnt != 0) begin
                up = cnt;
                for (int i = 0; i < cnt; i++) begin
                    if (loop_pitch(i) > v) begin
                        up = i;
                        break;
                    end
                end
                if (up == 0) begin
                    // target below the table
                    pl = loop_pitch(0);
                    loop_fade_q[0] = below_fade(pl, v);
                    if (loop_fade_q[0] != 0 && pl != 0) begin
                        ratio[0] = pitch_quotient(v, pl);
                        rt[0] = 1;
                    end
                    for (int i = 1; i < cnt; i++) loop_fade_q[i] = idle_gain(loop_pitch(i));
                end else if (up == cnt) begin
                    // target at or above the top slot
                    pl = loop_pitch(cnt - 1);
                    for (int i = 0; i < cnt - 1; i++) loop_fade_q[i] = idle_gain(loop_pitch(i));
                    loop_fade_q[cnt - 1] = UNITY;
                    if (pl != 0) begin
                        ratio[cnt - 1] = pitch_quotient(v, pl);
                        rt[cnt - 1] = 1;
                    end
                end else begin
                    // crossfade between the two neighbors
                    lo = up - 1;
                    pl = loop_pitch(lo);
                    pu = loop_pitch(up);
                    for (int i = 0; i < lo; i++) loop_fade_q[i] = idle_gain(loop_pitch(i));
                    if (pl != 0) begin
                        loop_fade_q[lo] = 16'((64'd32768 * (pu - v)) / (pu - pl));
                        ratio[lo] = pitch_quotient(v, pl);
                        rt[lo] = 1;
                    end else begin
                        loop_fade_q[lo] = UNITY;
                    end
                    if (pu != 0) begin
                        loop_fade_q[up] = 16'((64'd32768 * (v - pl)) / (pu - pl));
                        ratio[up] = pitch_quotient(v, pu);
                        rt[up] = 1;
                    end else begin
                        loop_fade_q[up] = UNITY;
                    end
                    for (int i = up + 1; i < cnt; i++) loop_fade_q[i] = idle_gain(loop_pitch(i));
                end
            end
            if (presence_q[1]) begin
                stop_fade_q = below_fade(stop_pitch_q, v);
                if (stop_fade_q != 0 && stop_pitch_q != 0) begin
                    stop_ratio = pitch_quotient(v, stop_pitch_q);
                    stop_rt = 1;
                end
            end
        end
        if (presence_q[0]) batch = {batch, make_result(SLOT_START, start_fade_q,
                                                       start_ratio, start_rt)};
        for (int i = 0; i < cnt; i++)
            batch = {batch, make_result(4'(i + 1), loop_fade_q[i], ratio[i], rt[i])};
        if (presence_q[1]) batch = {batch, make_result(SLOT_STOP, stop_fade_q,
                                                       stop_ratio, stop_rt)};
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) pending_results = {pending_results, batch[k]};
    endtask

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // sender has nothing to follow right away
    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    // one input transfer, with an optional random gap in front
    task automatic send_item(logic func, logic [15:0] value, bit gaps = 1'b1);
        int gap_n;
        gap_n = gaps ? $urandom_range(0, 12) : 0;
        if (gap_n != 0) begin
            idle_input();
            wait_cycles(gap_n);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= value;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_gains(func, value);
        items_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOOP_COUNT:  loop_count_q = data[3:0];
            CFG_PITCH_LOW:   pitch_low_q = data;
            CFG_PITCH_HIGH:  pitch_high_q = data;
            CFG_START_PITCH: start_pitch_q = data[15:0];
            CFG_STOP_PITCH:  stop_pitch_q = data[15:0];
            CFG_PRESENCE:    presence_q = data[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // block goes idle: nothing queued, then latency margin for result-less items
    task automatic wait_drained();
        idle_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        wait_cycles(DRAIN_CYCLES);
    endtask

    function automatic logic [63:0] pack_table(logic [15:0] a, logic [15:0] b,
                                               logic [15:0] c, logic [15:0] d);
        return {d, c, b, a};
    endfunction

    // ascending random table of four pitches, at most max_top
    function automatic logic [63:0] rand_table(int unsigned max_top);
        logic [15:0] p [4];
        int unsigned step;
        p[0] = 16'($urandom_range(16, max_top / 4));
        for (int k = 1; k < 4; k++) begin
            step = $urandom_range(1, max_top / 4);
            p[k] = 16'(p[k - 1] + step);
        end
        return pack_table(p[0], p[1], p[2], p[3]);
    endfunction

    // set up a full configuration, one write per register
    task automatic load_config(logic [3:0] cnt, logic [63:0] lo_w, logic [63:0] hi_w,
                               logic [15:0] sp, logic [15:0] tp, logic [1:0] pres);
        write_reg(CFG_LOOP_COUNT, {60'd0, cnt});
        write_reg(CFG_PITCH_LOW, lo_w);
        write_reg(CFG_PITCH_HIGH, hi_w);
        write_reg(CFG_START_PITCH, {48'd0, sp});
        write_reg(CFG_STOP_PITCH, {48'd0, tp});
        write_reg(CFG_PRESENCE, {62'd0, pres});
    endtask

    // ---------------- test tasks ----------------

    // extremes, both functions, unpitched slots, below/above table, empty set
    task automatic test_directed();
        // nothing present after reset: items give no result
        send_item(FUNC_PITCH, 16'h0100);
        wait_drained();
        load_config(4'd4, pack_table(16'd800, 16'd1600, 16'd3200, 16'd6400), 64'd0,
                    16'd1000, 16'd0, 2'b11);
        send_item(FUNC_PITCH, 16'd0);        // far below the table
        send_item(FUNC_PITCH, 16'd200);      // fade zone of slot 0
        send_item(FUNC_PITCH, 16'd1000);     // between neighbors
        send_item(FUNC_PITCH, 16'd1600);     // exactly on a slot
        send_item(FUNC_PITCH, 16'hFFFF);     // above the top, start slot ratio saturates
        send_item(FUNC_GAIN, 16'hFFFF);      // clamps to unity
        send_item(FUNC_GAIN, 16'd0);
        send_item(FUNC_PITCH, 16'd3000);
        send_item(FUNC_GAIN, 16'h4000);
        send_item(FUNC_PITCH, 16'd5000);
        wait_drained();
        // unpitched slots in the table, oversized loop count, unordered entries
        load_config(4'd15, pack_table(16'd0, 16'd500, 16'd0, 16'd300),
                    pack_table(16'd9000, 16'd4000, 16'd0, 16'hFFFF),
                    16'hFFFF, 16'd1, 2'b10);
        write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);   // unknown index, ignored
        send_item(FUNC_GAIN, 16'h8000);
        send_item(FUNC_PITCH, 16'd0);
        send_item(FUNC_PITCH, 16'd400);
        send_item(FUNC_PITCH, 16'd5000);
        send_item(FUNC_PITCH, 16'hFFFE);
        send_item(FUNC_PITCH, 16'h5555);
        send_item(FUNC_PITCH, 16'hAAAA);
        wait_drained();
        load_config(4'd0, 64'd0, 64'd0, 16'd0, 16'd0, 2'b00);
        send_item(FUNC_PITCH, 16'd100);      // no present slot at all
        wait_drained();
    endtask

    // random pitch targets, with some gain items, over random tables whose halves each ascend
    task automatic test_random_tables(int n_items);
        int unsigned top;
        for (int phase = 0; phase < 8; phase++) begin
            top = (phase % 2) ? 16'hFFFF / 2 : 4000;
            load_config(4'($urandom_range(1, 8)), rand_table(top / 2), rand_table(top),
                        16'($urandom_range(0, top)), 16'($urandom_range(0, top)),
                        2'($urandom_range(0, 3)));
            for (int k = 0; k < n_items / 8; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(FUNC_GAIN, 16'($urandom_range(0, 16'hFFFF)));
                else if ($urandom_range(0, 7) == 0)
                    send_item(FUNC_PITCH, 16'($urandom));
                else
                    send_item(FUNC_PITCH, 16'($urandom_range(0, top + top / 4)));
            end
            wait_drained();
        end
    endtask

    // raw register noise, with every other item sent with no sender gap
    task automatic test_noise_and_pressure(int n_items);
        load_config(4'($urandom_range(0, 15)), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom), 16'($urandom), 2'b11);
        for (int k = 0; k < n_items; k++) begin
            send_item(1'($urandom_range(0, 1)), 16'($urandom), 1'(k % 2));
            if (k == n_items / 2) begin
                // hold off until the block has emptied
                idle_input();
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end
        wait_drained();
    endtask

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            t_slot_result exp_r;
            results_seen++;
            if (m_tuser) retuned_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: slot %0d", m_tdata[3:0]);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[3:0] !== exp_r.slot) begin
                    $error("slot: expected %0d, got %0d", exp_r.slot, m_tdata[3:0]);
                    error_count++;
                end
                if (m_tdata[19:4] !== exp_r.slot_gain) begin
                    $error("slot_gain: expected %0d, got %0d", exp_r.slot_gain, m_tdata[19:4]);
                    error_count++;
                end
                if (m_tdata[35:20] !== exp_r.pitch_ratio) begin
                    $error("pitch_ratio: expected %0d, got %0d", exp_r.pitch_ratio,
                           m_tdata[35:20]);
                    error_count++;
                end
                if (m_tuser !== exp_r.retune) begin
                    $error("retune: expected %0d, got %0d", exp_r.retune, m_tuser);
                    error_count++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls, drawn per result, with stall-free stretches
    initial begin
        int wait_n;
        forever begin
            wait_n = sink_stall_on ? $urandom_range(0, 12) : 0;
            if (wait_n != 0) begin
                m_tready <= 1'b0;
                wait_cycles(wait_n);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) sink_stall_on = !sink_stall_on;
        end
    end

    // watchdog on transfer-free cycles
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || (!s_tvalid && !cfg_valid && pending_results.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("pitch_layer_crossfade_gains test failed");
            $finish;
        end
    end

    initial begin
        loop_count_q = 0; pitch_low_q = 0; pitch_high_q = 0;
        start_pitch_q = 0; stop_pitch_q = 0; presence_q = 0;
        for (int i = 0; i < MAX_LOOP_SLOTS; i++) loop_fade_q[i] = 0;
        start_fade_q = 0; stop_fade_q = 0; master_gain_q = UNITY;
        wait_cycles(11);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_tables(400);
        test_noise_and_pressure(48);

        wait_drained();
        $display("covered %0d items, %0d results (%0d retuned)", items_sent,
                 results_seen, retuned_seen);
        $display("configurations: directed, eight random tables, raw register noise");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("pitch_layer_crossfade_gains test passed");
        end else begin
            $display("pitch_layer_crossfade_gains test failed");
        end
        $finish;
    end

endmodule
